// File: sv/mrtt_pkg.sv
// Shared types and constants for the multi-resolution timer table.
`timescale 1ns / 1ps

package mrtt_pkg;

   // Request operations.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Number of resolution banks and the invalid bank code.
   localparam int unsigned BANKS = 3;
   localparam logic [1:0] RES_INVALID = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // Status codes.
   localparam logic [2:0] CODE_OK        = 3'd0;
   localparam logic [2:0] CODE_BAD_TASK  = 3'd1;
   localparam logic [2:0] CODE_BAD_DUR   = 3'd2;
   localparam logic [2:0] CODE_BAD_TYPE  = 3'd3;
   localparam logic [2:0] CODE_BAD_INDEX = 3'd4;
   localparam logic [2:0] CODE_BAD_RES   = 3'd5;

   // Entry states.
   localparam logic [1:0] ENT_OFF     = 2'd0;
   localparam logic [1:0] ENT_STARTED = 2'd1;
   localparam logic [1:0] ENT_ACTIVE  = 2'd2;
   localparam logic [1:0] ENT_STOPPED = 2'd3;

   // One timer entry as held in the store.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  owner;
      logic        claimed;
      logic [31:0] length;
      logic        periodic;
      logic [31:0] remaining;
   } mrtt_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic reject;
      logic read_entry;
      logic apply;
      logic scan_init;
      logic scan_run;
      logic finish;
   } mrtt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       bad;
      logic       scan_done;
   } mrtt_status_type;

endpackage

// File: sv/mrtt_ctrl.sv
// Controller state machine for the multi-resolution timer table.
`timescale 1ns / 1ps

module mrtt_ctrl
   import mrtt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  mrtt_status_type status,
   output mrtt_cmd_type    cmd,
   output logic            busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_APPLY  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (status.op) inside
               OP_START, OP_STOP: begin
                  if (status.bad) begin
                     cmd.reject = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.read_entry = 1'b1;
                     state_in       = S_APPLY;
                  end
               end
               OP_TICK: begin
                  if (status.bad) begin
                     cmd.reject = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Commands never overlap.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("mrtt_ctrl: more than one command issued");

   // A new transaction is taken only when idle.
   assert property (@(posedge clock) disable iff (reset) cmd.capture |-> !busy)
      else $error("mrtt_ctrl: capture while busy");

   // Applying a start or stop hands back to idle at once.
   assert property (@(posedge clock) disable iff (reset) cmd.apply |=> !busy)
      else $error("mrtt_ctrl: not idle after apply");

endmodule

// File: sv/mrtt_datapath.sv
// Datapath of the multi-resolution timer table: checks, entry store, scan and results.
`timescale 1ns / 1ps

module mrtt_datapath
   import mrtt_pkg::*;
#(
   parameter int unsigned TIMERS_PER_BANK = 16,
   parameter int unsigned TASK_LIMIT      = 32
)
(
   input  logic            clock,
   input  logic            reset,
   input  mrtt_cmd_type    cmd,
   output mrtt_status_type status,
   input  logic [1:0]      req_op,
   input  logic [1:0]      req_resolution,
   input  logic [7:0]      req_task_id,
   input  logic [7:0]      req_timer_index,
   input  logic [31:0]     req_duration,
   input  logic [1:0]      req_timer_kind,
   input  logic            csr_we,
   input  logic [31:0]     csr_wdata,
   output logic            rsp_valid,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_status_code,
   output logic [7:0]      rsp_fired_index,
   output logic [1:0]      rsp_fired_resolution,
   output logic [7:0]      rsp_owner_task,
   output logic [15:0]     rsp_errors_seen,
   output logic            rsp_last
);

   localparam int unsigned DEPTH = BANKS * TIMERS_PER_BANK;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned IW    = $clog2(TIMERS_PER_BANK);
   localparam int unsigned CW    = $clog2(TIMERS_PER_BANK + 1);
   localparam logic [AW-1:0] TPB_A   = AW'(TIMERS_PER_BANK);
   localparam logic [CW-1:0] TPB_C   = CW'(TIMERS_PER_BANK);
   localparam logic [7:0]    TPB_8   = 8'(TIMERS_PER_BANK);
   localparam logic [8:0]    TLIM_9  = 9'(TASK_LIMIT);

   // Captured request and configuration.
   logic [1:0]  op_ff;
   logic [1:0]  res_ff;
   logic [7:0]  task_ff;
   logic [7:0]  idx_ff;
   logic [31:0] dur_ff;
   logic [1:0]  tkind_ff;
   logic [31:0] max_dur_ff;
   logic [15:0] rej_ff;
   logic [15:0] rej_in;

   // Scan pointers.
   logic [CW-1:0] rd_idx_ff;
   logic [CW-1:0] rd_idx_in;
   logic          pend_ff;
   logic          pend_in;
   logic [IW-1:0] pend_idx_ff;

   // Entry store and its valid bits.
   mrtt_entry_type mem_ram [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   mrtt_entry_type rd_q_ff;
   logic           rd_valid_ff;
   mrtt_entry_type old_entry;
   mrtt_entry_type new_entry;
   logic [AW-1:0]  base_addr;
   logic [AW-1:0]  idx_addr;
   logic [AW-1:0]  scan_addr;
   logic [AW-1:0]  pend_addr;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic           wr_en;
   logic           rd_en;
   logic           fire;

   // Request checks.
   logic       task_bad;
   logic       dur_bad;
   logic       type_bad;
   logic [2:0] place_code;
   logic [2:0] chk_code;

   // Output registers.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [2:0]  rsp_code_ff;
   logic [7:0]  rsp_idx_ff;
   logic [1:0]  rsp_res_ff;
   logic [7:0]  rsp_owner_ff;
   logic [15:0] rsp_err_ff;
   logic        rsp_last_ff;

   // Capture the request when the transaction is accepted.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         res_ff   <= req_resolution;
         task_ff  <= req_task_id;
         idx_ff   <= req_timer_index;
         dur_ff   <= req_duration;
         tkind_ff <= req_timer_kind;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dur_ff <= '1;
      end else if (csr_we) begin
         max_dur_ff <= csr_wdata;
      end
   end

   // Checks in the order start and stop require.
   always_comb begin
      task_bad = (task_ff == 8'd0) || ({1'b0, task_ff} >= TLIM_9);
      dur_bad  = (dur_ff == 32'd0) || (dur_ff > max_dur_ff);
      type_bad = (tkind_ff > 2'd1);
      if (res_ff == RES_INVALID) begin
         place_code = CODE_BAD_RES;
      end else if ((idx_ff == 8'd0) || (idx_ff >= TPB_8)) begin
         place_code = CODE_BAD_INDEX;
      end else begin
         place_code = CODE_OK;
      end
      case (op_ff)
         OP_START: begin
            if (task_bad) begin
               chk_code = CODE_BAD_TASK;
            end else if (dur_bad) begin
               chk_code = CODE_BAD_DUR;
            end else if (type_bad) begin
               chk_code = CODE_BAD_TYPE;
            end else begin
               chk_code = place_code;
            end
         end
         OP_STOP: begin
            chk_code = task_bad ? CODE_BAD_TASK : place_code;
         end
         OP_TICK: begin
            chk_code = (res_ff == RES_INVALID) ? CODE_BAD_RES : CODE_OK;
         end
         default: chk_code = CODE_OK;
      endcase
   end

   assign status.op        = op_ff;
   assign status.bad       = (chk_code != CODE_OK);
   assign status.scan_done = (rd_idx_ff == TPB_C);

   // Saturating reject counter.
   assign rej_in = (rej_ff == '1) ? rej_ff : rej_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rej_ff <= '0;
      end else if (cmd.reject) begin
         rej_ff <= rej_in;
      end
   end

   // Scan pointers: one read issued per cycle, data processed the cycle after.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      pend_in   = pend_ff;
      if (cmd.scan_init) begin
         rd_idx_in = '0;
         pend_in   = 1'b0;
      end else if (cmd.scan_run) begin
         if (rd_idx_ff != TPB_C) begin
            rd_idx_in = rd_idx_ff + CW'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_run) begin
         pend_idx_ff <= rd_idx_ff[IW-1:0];
      end
   end

   // Store addressing.
   assign base_addr = AW'(res_ff) * TPB_A;
   assign idx_addr  = base_addr + AW'(idx_ff);
   assign scan_addr = base_addr + AW'(rd_idx_ff[IW-1:0]);
   assign pend_addr = base_addr + AW'(pend_idx_ff);
   assign rd_addr   = cmd.scan_run ? scan_addr : idx_addr;
   assign rd_en     = cmd.read_entry || cmd.scan_run;
   assign wr_addr   = cmd.apply ? idx_addr : pend_addr;
   assign wr_en     = cmd.apply || (cmd.scan_run && pend_ff);

   // An entry never written reads as its reset value of all zeros.
   assign old_entry = rd_valid_ff ? rd_q_ff : '0;

   // Entry update for start, stop and one scan step.
   always_comb begin
      new_entry = old_entry;
      fire      = 1'b0;
      if (cmd.apply) begin
         case (op_ff)
            OP_START: begin
               new_entry.owner    = task_ff;
               new_entry.claimed  = 1'b1;
               new_entry.length   = dur_ff;
               new_entry.periodic = tkind_ff[0];
               new_entry.status   = ENT_STARTED;
            end
            OP_STOP: begin
               if (old_entry.claimed && (old_entry.owner == task_ff)) begin
                  new_entry.status = ENT_STOPPED;
               end else begin
                  new_entry.status = ENT_OFF;
               end
            end
            default: new_entry = old_entry;
         endcase
      end else if (old_entry.status == ENT_ACTIVE) begin
         if (old_entry.remaining != 32'd0) begin
            new_entry.remaining = old_entry.remaining - 32'd1;
         end else begin
            fire = 1'b1;
            if (old_entry.periodic) begin
               new_entry.remaining = old_entry.length - 32'd1;
            end else begin
               new_entry.status    = ENT_STOPPED;
               new_entry.remaining = 32'd0;
            end
         end
      end else if (old_entry.status == ENT_STARTED) begin
         new_entry.remaining = old_entry.length;
         new_entry.status    = ENT_ACTIVE;
      end
   end

   // Entry memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ram[wr_addr] <= new_entry;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ram[rd_addr];
      end
   end

   // Valid bits, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.reject || cmd.apply || cmd.finish
                         || (cmd.scan_run && pend_ff && fire);
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         rsp_kind_ff  <= (op_ff == OP_TICK) ? KIND_END : KIND_STATUS;
         rsp_code_ff  <= chk_code;
         rsp_idx_ff   <= 8'd0;
         rsp_res_ff   <= (op_ff == OP_TICK) ? res_ff : 2'd0;
         rsp_owner_ff <= 8'd0;
         rsp_err_ff   <= rej_in;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.apply) begin
         rsp_kind_ff  <= KIND_STATUS;
         rsp_code_ff  <= CODE_OK;
         rsp_idx_ff   <= 8'd0;
         rsp_res_ff   <= 2'd0;
         rsp_owner_ff <= 8'd0;
         rsp_err_ff   <= rej_ff;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.finish) begin
         rsp_kind_ff  <= KIND_END;
         rsp_code_ff  <= CODE_OK;
         rsp_idx_ff   <= 8'd0;
         rsp_res_ff   <= res_ff;
         rsp_owner_ff <= 8'd0;
         rsp_err_ff   <= rej_ff;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.scan_run && pend_ff && fire) begin
         rsp_kind_ff  <= KIND_TIMEOUT;
         rsp_code_ff  <= CODE_OK;
         rsp_idx_ff   <= 8'(pend_idx_ff);
         rsp_res_ff   <= res_ff;
         rsp_owner_ff <= old_entry.owner;
         rsp_err_ff   <= rej_ff;
         rsp_last_ff  <= 1'b0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_status_code      = rsp_code_ff;
   assign rsp_fired_index      = rsp_idx_ff;
   assign rsp_fired_resolution = rsp_res_ff;
   assign rsp_owner_task       = rsp_owner_ff;
   assign rsp_errors_seen      = rsp_err_ff;
   assign rsp_last             = rsp_last_ff;

   // The scan pointer never runs past the bank.
   assert property (@(posedge clock) disable iff (reset) rd_idx_ff <= TPB_C)
      else $error("mrtt_datapath: scan pointer beyond bank");

   // A timeout is never the closing result of a tick.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_TIMEOUT)) |-> !rsp_last_ff)
      else $error("mrtt_datapath: timeout marked last");

   // The reject counter never goes down outside reset.
   assert property (@(posedge clock) disable iff (reset)
      !reset |=> (rej_ff >= $past(rej_ff)))
      else $error("mrtt_datapath: reject counter decreased");

   // Finishing a scan gives a closing end result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_valid_ff && rsp_last_ff && (rsp_kind_ff == KIND_END)))
      else $error("mrtt_datapath: scan end result missing");

endmodule

// File: sv/multi_resolution_timer_table_top.sv
// Top level of the multi-resolution timer table: controller and datapath.
// Start and stop pass from acceptance through the evaluate and apply states back to
// idle; the status result is registered from the apply command (or from the reject
// command for a rejected transaction). A tick scans the bank, reading one store entry
// per cycle; each firing entry streams out a timeout, the end result comes last.
// The receiver cannot stall; each result is shown for one cycle under rsp_valid.
// Synchronous reset clears the controller, the error counter and all entry valid bits.
`timescale 1ns / 1ps

module multi_resolution_timer_table_top
   import mrtt_pkg::*;
#(
   parameter int unsigned TIMERS_PER_BANK = 16,
   parameter int unsigned TASK_LIMIT      = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_resolution,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_timer_index,
   input  logic [31:0] req_duration,
   input  logic [1:0]  req_timer_kind,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_status_code,
   output logic [7:0]  rsp_fired_index,
   output logic [1:0]  rsp_fired_resolution,
   output logic [7:0]  rsp_owner_task,
   output logic [15:0] rsp_errors_seen,
   output logic        rsp_last
);

   mrtt_cmd_type    cmd;
   mrtt_status_type status;

   // Sequencing of each transaction.
   mrtt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Checks, timer store and result registers.
   mrtt_datapath #(
      .TIMERS_PER_BANK (TIMERS_PER_BANK),
      .TASK_LIMIT      (TASK_LIMIT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_op               (req_op),
      .req_resolution       (req_resolution),
      .req_task_id          (req_task_id),
      .req_timer_index      (req_timer_index),
      .req_duration         (req_duration),
      .req_timer_kind       (req_timer_kind),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_kind             (rsp_kind),
      .rsp_status_code      (rsp_status_code),
      .rsp_fired_index      (rsp_fired_index),
      .rsp_fired_resolution (rsp_fired_resolution),
      .rsp_owner_task       (rsp_owner_task),
      .rsp_errors_seen      (rsp_errors_seen),
      .rsp_last             (rsp_last)
   );

endmodule

// File: tb/multi_resolution_timer_table_top_tb.sv
// Self-checking testbench for the multi-resolution timer table top level.
`timescale 1ns / 1ps

module multi_resolution_timer_table_top_tb;
   import mrtt_pkg::*;

   localparam int unsigned TPB              = 16;
   localparam int unsigned TASKS            = 32;
   localparam int unsigned ENTRIES          = BANKS * TPB;
   localparam int unsigned CYCLE_LIMIT      = 1_500_000;
   localparam int unsigned SETTLE_CYCLES    = TPB + 8;
   localparam int unsigned RANDOM_PER_PHASE = 65;
   localparam int unsigned TAIL_ITEMS       = 20;
   localparam int unsigned MAX_REPORTS      = 100;

   // One request transaction as presented on the req_ ports.
   typedef struct {
      logic [1:0]  op;
      logic [1:0]  resolution;
      logic [7:0]  task_id;
      logic [7:0]  timer_index;
      logic [31:0] duration;
      logic [1:0]  timer_kind;
   } request_type;

   // One response transaction as seen on the rsp_ ports.
   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  status_code;
      logic [7:0]  fired_index;
      logic [1:0]  fired_resolution;
      logic [7:0]  owner_task;
      logic [15:0] errors_seen;
      logic        last;
   } response_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_op;
   logic [1:0]  req_resolution;
   logic [7:0]  req_task_id;
   logic [7:0]  req_timer_index;
   logic [31:0] req_duration;
   logic [1:0]  req_timer_kind;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_status_code;
   logic [7:0]  rsp_fired_index;
   logic [1:0]  rsp_fired_resolution;
   logic [7:0]  rsp_owner_task;
   logic [15:0] rsp_errors_seen;
   logic        rsp_last;

   multi_resolution_timer_table_top #(
      .TIMERS_PER_BANK(TPB),
      .TASK_LIMIT(TASKS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_resolution(req_resolution),
      .req_task_id(req_task_id),
      .req_timer_index(req_timer_index),
      .req_duration(req_duration),
      .req_timer_kind(req_timer_kind),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_kind(rsp_kind),
      .rsp_status_code(rsp_status_code),
      .rsp_fired_index(rsp_fired_index),
      .rsp_fired_resolution(rsp_fired_resolution),
      .rsp_owner_task(rsp_owner_task),
      .rsp_errors_seen(rsp_errors_seen),
      .rsp_last(rsp_last)
   );

   // Timer table shadow: updates its own copy of the store on every accepted
   // request and queues the responses that request must produce.
   class timer_scoreboard;
      bit [31:0] max_duration;
      bit [1:0]  ent_status    [ENTRIES];
      bit [7:0]  ent_owner     [ENTRIES];
      bit        ent_claimed   [ENTRIES];
      bit [31:0] ent_length    [ENTRIES];
      bit        ent_periodic  [ENTRIES];
      bit [31:0] ent_remaining [ENTRIES];
      bit [15:0] reject_count;
      response_type awaited_rsp[$];
      int unsigned failures;

      function new();
         max_duration = '1;
         reject_count = '0;
         failures = 0;
      endfunction

      function void push_rsp(logic [1:0] kind, logic [2:0] code, logic [7:0] idx,
                             logic [1:0] res, logic [7:0] owner, logic last);
         response_type rsp;
         rsp.kind = kind;
         rsp.status_code = code;
         rsp.fired_index = idx;
         rsp.fired_resolution = res;
         rsp.owner_task = owner;
         rsp.errors_seen = reject_count;
         rsp.last = last;
         awaited_rsp.push_back(rsp);
      endfunction

      function logic [2:0] place_code(logic [1:0] res, logic [7:0] idx);
         if (res >= BANKS) return CODE_BAD_RES;
         if (idx == 0 || idx >= TPB) return CODE_BAD_INDEX;
         return CODE_OK;
      endfunction

      // The counter saturates at its full value.
      function void bump_rejects();
         if (reject_count != 16'hFFFF) reject_count++;
      endfunction

      function void note_request(request_type r);
         logic [2:0] code;
         int unsigned e;
         int unsigned i;
         code = CODE_OK;
         e = r.resolution * TPB + r.timer_index;
         case (r.op)
            OP_START: begin
               // Checks run in a fixed order; the first failure wins.
               if (r.task_id == 0 || r.task_id >= TASKS) code = CODE_BAD_TASK;
               else if (r.duration == 0 || r.duration > max_duration) code = CODE_BAD_DUR;
               else if (r.timer_kind > 1) code = CODE_BAD_TYPE;
               else code = place_code(r.resolution, r.timer_index);
               if (code != CODE_OK) begin
                  bump_rejects();
               end else begin
                  ent_owner[e] = r.task_id;
                  ent_claimed[e] = 1'b1;
                  ent_length[e] = r.duration;
                  ent_periodic[e] = r.timer_kind[0];
                  ent_status[e] = ENT_STARTED;
               end
               push_rsp(KIND_STATUS, code, '0, '0, '0, 1'b1);
            end
            OP_STOP: begin
               if (r.task_id == 0 || r.task_id >= TASKS) code = CODE_BAD_TASK;
               else code = place_code(r.resolution, r.timer_index);
               if (code != CODE_OK) begin
                  bump_rejects();
               end else if (ent_claimed[e] && ent_owner[e] == r.task_id) begin
                  ent_status[e] = ENT_STOPPED;
               end else begin
                  // A foreign or never-started entry is switched off instead.
                  ent_status[e] = ENT_OFF;
               end
               push_rsp(KIND_STATUS, code, '0, '0, '0, 1'b1);
            end
            OP_TICK: begin
               if (r.resolution >= BANKS) begin
                  bump_rejects();
                  push_rsp(KIND_END, CODE_BAD_RES, '0, r.resolution, '0, 1'b1);
               end else begin
                  // Scan the bank in index order, firing expired entries.
                  for (i = 0; i < TPB; i++) begin
                     e = r.resolution * TPB + i;
                     if (ent_status[e] == ENT_ACTIVE) begin
                        if (ent_remaining[e] != 0) begin
                           ent_remaining[e]--;
                        end else begin
                           if (ent_periodic[e]) begin
                              ent_remaining[e] = ent_length[e] - 1;
                           end else begin
                              ent_status[e] = ENT_STOPPED;
                              ent_remaining[e] = '0;
                           end
                           push_rsp(KIND_TIMEOUT, CODE_OK, i[7:0], r.resolution,
                                    ent_owner[e], 1'b0);
                        end
                     end else if (ent_status[e] == ENT_STARTED) begin
                        ent_remaining[e] = ent_length[e];
                        ent_status[e] = ENT_ACTIVE;
                     end
                  end
                  push_rsp(KIND_END, CODE_OK, '0, r.resolution, '0, 1'b1);
               end
            end
            default: begin
               // The unused operation is ignored and gives no response.
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
         if (expv !== actv) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: %s expected %0h actual %0h", $time, name, expv, actv);
         end
      endfunction

      function void check_response(response_type got);
         response_type expd;
         if (awaited_rsp.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: response with none expected, expected none actual kind %0h",
                        $time, got.kind);
         end else begin
            expd = awaited_rsp.pop_front();
            compare_field("rsp_kind", 32'(expd.kind), 32'(got.kind));
            compare_field("rsp_status_code", 32'(expd.status_code),
                          32'(got.status_code));
            compare_field("rsp_fired_index", 32'(expd.fired_index),
                          32'(got.fired_index));
            compare_field("rsp_fired_resolution", 32'(expd.fired_resolution),
                          32'(got.fired_resolution));
            compare_field("rsp_owner_task", 32'(expd.owner_task), 32'(got.owner_task));
            compare_field("rsp_errors_seen", 32'(expd.errors_seen),
                          32'(got.errors_seen));
            compare_field("rsp_last", 32'(expd.last), 32'(got.last));
         end
      endfunction
   endclass

   timer_scoreboard sb;
   response_type seen_rsp;
   int unsigned cycle_count;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run guard: ends the simulation as a failure once the cycle limit is reached.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("multi_resolution_timer_table_top_tb NOT OK");
      $finish;
   end

   // Every strobed response transaction is checked against the oldest one awaited.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         seen_rsp.kind = rsp_kind;
         seen_rsp.status_code = rsp_status_code;
         seen_rsp.fired_index = rsp_fired_index;
         seen_rsp.fired_resolution = rsp_fired_resolution;
         seen_rsp.owner_task = rsp_owner_task;
         seen_rsp.errors_seen = rsp_errors_seen;
         seen_rsp.last = rsp_last;
         sb.check_response(seen_rsp);
      end
   end

   function automatic request_type make_request(logic [1:0] op, logic [1:0] res,
                                                logic [7:0] task_id, logic [7:0] idx,
                                                logic [31:0] dur, logic [1:0] tkind);
      request_type r;
      r.op = op;
      r.resolution = res;
      r.task_id = task_id;
      r.timer_index = idx;
      r.duration = dur;
      r.timer_kind = tkind;
      return r;
   endfunction

   // Mostly well-formed requests on a few owners with short durations, so that
   // timers really start, expire and reload; the remainder is raw noise.
   function automatic request_type random_request();
      request_type r;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      r = make_request(OP_TICK, 2'($urandom_range(0, BANKS - 1)), 8'($urandom_range(1, 4)),
                       8'($urandom_range(1, TPB - 1)), 32'($urandom_range(1, 4)),
                       2'($urandom_range(0, 1)));
      if (sel < 35) begin
         r.op = OP_START;
         case ($urandom_range(0, 9))
            0: r.duration = $urandom();
            1: r.duration = sb.max_duration + 32'($urandom_range(0, 1));
            2: r.duration = 32'($urandom_range(1, 12));
            default: ;
         endcase
      end else if (sel < 47) begin
         r.op = OP_STOP;
      end else if (sel >= 87) begin
         r = make_request(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          $urandom(), 2'($urandom_range(0, 3)));
      end
      return r;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic send_request(request_type r);
      req_op <= r.op;
      req_resolution <= r.resolution;
      req_task_id <= r.task_id;
      req_timer_index <= r.timer_index;
      req_duration <= r.duration;
      req_timer_kind <= r.timer_kind;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(r);
   endtask

   // Drop start and wait until every awaited response has arrived.
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // Random gaps between transactions, and now and then a full drain.
   task automatic idle_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         drain_responses();
      end else if (sel < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // The limit register is only written once the block has gone idle.
   task automatic write_max_duration(logic [31:0] value);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.max_duration = value;
      csr_we <= 1'b0;
   endtask

   // Stimulus: directed corner cases, random phases under several limits,
   // then a short gap-free tail.
   initial begin
      request_type directed[$];
      logic [31:0] limits[4];
      int unsigned phase;
      int unsigned n;
      sb = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_op <= OP_START;
      req_resolution <= '0;
      req_task_id <= '0;
      req_timer_index <= '0;
      req_duration <= '0;
      req_timer_kind <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Rejections in check order, then a short life of real timers.
      directed.push_back(make_request(OP_START, 2'd0, 8'd0, 8'd1, 32'd1, 2'd0));
      directed.push_back(make_request(OP_START, 2'd0, 8'd32, 8'd1, 32'd1, 2'd0));
      directed.push_back(make_request(OP_START, 2'd3, 8'd255, 8'd0, 32'd0, 2'd3));
      directed.push_back(make_request(OP_START, 2'd0, 8'd1, 8'd1, 32'd0, 2'd0));
      directed.push_back(make_request(OP_START, 2'd0, 8'd1, 8'd1, 32'd5, 2'd2));
      directed.push_back(make_request(OP_START, 2'd3, 8'd1, 8'd0, 32'd5, 2'd1));
      directed.push_back(make_request(OP_START, 2'd0, 8'd1, 8'd0, 32'd5, 2'd0));
      directed.push_back(make_request(OP_START, 2'd1, 8'd1, 8'd16, 32'd5, 2'd0));
      directed.push_back(make_request(OP_START, 2'd2, 8'd31, 8'd255, 32'hFFFF_FFFF, 2'd1));
      directed.push_back(make_request(OP_STOP, 2'd3, 8'd0, 8'd1, 32'd0, 2'd0));
      directed.push_back(make_request(OP_STOP, 2'd3, 8'd5, 8'd1, 32'd0, 2'd0));
      directed.push_back(make_request(OP_STOP, 2'd1, 8'd5, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(OP_STOP, 2'd1, 8'd5, 8'd7, 32'd0, 2'd0));
      directed.push_back(make_request(OP_START, 2'd0, 8'd1, 8'd1, 32'd1, 2'd0));
      directed.push_back(make_request(OP_START, 2'd0, 8'd31, 8'd15, 32'd2, 2'd1));
      directed.push_back(make_request(OP_START, 2'd0, 8'd2, 8'd8, 32'hFFFF_FFFF, 2'd1));
      directed.push_back(make_request(OP_START, 2'd0, 8'd3, 8'd9, 32'd1, 2'd1));
      directed.push_back(make_request(OP_STOP, 2'd0, 8'd4, 8'd9, 32'd0, 2'd0));
      directed.push_back(make_request(OP_TICK, 2'd0, 8'd0, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(OP_TICK, 2'd0, 8'd0, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(OP_TICK, 2'd0, 8'd0, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(OP_TICK, 2'd0, 8'd0, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(OP_STOP, 2'd0, 8'd31, 8'd15, 32'd0, 2'd0));
      directed.push_back(make_request(OP_TICK, RES_INVALID, 8'd0, 8'd0, 32'd0, 2'd0));
      directed.push_back(make_request(2'd3, 2'd0, 8'd1, 8'd1, 32'd1, 2'd0));

      write_max_duration(32'hFFFF_FFFF);
      foreach (directed[i]) begin
         send_request(directed[i]);
         idle_gap();
      end

      // Random phases under the narrowest, a small, a random and the widest limit.
      limits[0] = 32'd1;
      limits[1] = 32'd7;
      limits[2] = 32'($urandom_range(2, 32'hFFFF_FFFE));
      limits[3] = 32'hFFFF_FFFF;
      for (phase = 0; phase < 4; phase++) begin
         write_max_duration(limits[phase]);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(random_request());
            if (phase != 3) idle_gap();
         end
      end

      // Gap-free tail.
      for (n = 0; n < TAIL_ITEMS; n++) send_request(random_request());

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("multi_resolution_timer_table_top_tb OK");
      end else begin
         $display("multi_resolution_timer_table_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
sv/mrtt_pkg.sv
sv/mrtt_ctrl.sv
sv/mrtt_datapath.sv
sv/multi_resolution_timer_table_top.sv
tb/multi_resolution_timer_table_top_tb.sv
